/* sv/gbc_pkg.sv */
package gbc_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int MARK_COUNT_DEF   = 16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_FORE_BLOCKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BLOCKS  = 4'd1;

    typedef enum logic [1:0] {
        CMD_MOVE  = 2'd0,
        CMD_WMARK = 2'd1,
        CMD_WBYTE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [11:0]        position;
        logic [3:0]         mark_index;
        logic signed [15:0] mark_block;
        logic [7:0]         text_byte;
    } t_item;

    typedef struct packed {
        logic [11:0]        gap_low;
        logic [11:0]        gap_high;
        logic [11:0]        mark_position;
        logic signed [15:0] mark_block_out;
        logic [7:0]         byte_out;
    } t_result;

    // requests from the sequencer to the mark unit
    typedef struct packed {
        logic scan;
        logic write;
        logic read;
    } t_mark_ctl;

    // requests from the sequencer to the copy unit
    typedef struct packed {
        logic start;
        logic dir_up;
        logic wr;
        logic rd;
    } t_copy_ctl;

endpackage

/* sv/gbc_ram.sv */
module gbc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/gbc_mark_unit.sv */
module gbc_mark_unit #(
    parameter int BUFFER_BYTES = gbc_pkg::BUFFER_BYTES_DEF,
    parameter int MARK_COUNT   = gbc_pkg::MARK_COUNT_DEF,
    parameter int PW           = 12,
    parameter int MIW          = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gbc_pkg::t_mark_ctl   i_ctl,
    input  logic [MIW-1:0]       i_idx,
    input  logic [PW-1:0]        i_wr_pos,
    input  logic [15:0]          i_wr_blk,
    input  logic [PW-1:0]        i_target,
    input  logic [PW-1:0]        i_gap_start,
    input  logic [PW-1:0]        i_gap_end,
    input  logic [14:0]          i_fore_cnt,
    input  logic [14:0]          i_end_cnt,
    output logic                 o_busy,
    output logic [PW-1:0]        o_rd_pos,
    output logic [15:0]          o_rd_blk
);

    localparam int EW = PW + 16;
    localparam logic [PW-1:0] RST_POS = PW'(BUFFER_BYTES - 1);

    logic [MARK_COUNT-1:0] r_vld;
    logic                  r_vld_q;
    logic                  r_scan;
    logic [MIW-1:0]        r_k;
    logic                  r_pend;
    logic [MIW-1:0]        r_pend_k;

    logic           we;
    logic [MIW-1:0] waddr;
    logic [EW-1:0]  wdata;
    logic           re;
    logic [MIW-1:0] raddr;
    logic [EW-1:0]  q;

    logic [PW-1:0] cur_pos;
    logic [15:0]   cur_blk;
    logic [PW-1:0] new_pos;
    logic [15:0]   new_blk;
    logic [PW-1:0] gap_size;
    logic          drop;

    gbc_ram #(
        .DEPTH (MARK_COUNT),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    // an entry never written holds its reset value
    assign cur_pos  = r_vld_q ? q[EW-1:16] : RST_POS;
    assign cur_blk  = r_vld_q ? q[15:0] : 16'd0;
    assign gap_size = i_gap_end - i_gap_start;

    always_comb begin
        new_pos = cur_pos;
        new_blk = cur_blk;
        drop    = 1'b0;
        if (cur_blk != 16'd0) begin
            // spilled mark: drop it when its block lies past the extension
            if (cur_blk[15]) begin
                drop = (~cur_blk) > {1'b0, i_end_cnt};
            end else begin
                drop = (cur_blk - 16'd1) > {1'b0, i_fore_cnt};
            end
            if (drop) begin
                new_pos = '0;
                new_blk = 16'd0;
            end
        end else if (cur_pos != '0) begin
            priority if (i_target < i_gap_start && cur_pos >= i_target
                         && cur_pos <= i_gap_start) begin
                new_pos = cur_pos + gap_size;
            end else if (i_target > i_gap_end && cur_pos >= i_gap_end
                         && cur_pos < i_target) begin
                new_pos = cur_pos - gap_size;
            end else if (cur_pos >= i_gap_start && cur_pos < i_gap_end) begin
                new_pos = i_gap_start;
            end else begin
                new_pos = cur_pos;
            end
        end
    end

    assign we    = r_pend | i_ctl.write;
    assign waddr = r_pend ? r_pend_k : i_idx;
    assign wdata = r_pend ? {new_pos, new_blk} : {i_wr_pos, i_wr_blk};
    assign re    = r_scan | i_ctl.read;
    assign raddr = r_scan ? r_k : i_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_scan <= 1'b0;
            r_pend <= 1'b0;
            r_k    <= '0;
        end else begin
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
            r_pend <= r_scan;
            if (i_ctl.scan) begin
                r_scan <= 1'b1;
                r_k    <= '0;
            end else if (r_scan) begin
                if (r_k == MIW'(MARK_COUNT - 1)) begin
                    r_scan <= 1'b0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_k <= r_k;
        if (re) begin
            r_vld_q <= r_vld[raddr];
        end
    end

    assign o_busy   = r_scan | r_pend;
    assign o_rd_pos = cur_pos;
    assign o_rd_blk = cur_blk;

endmodule

/* sv/gbc_copy_unit.sv */
module gbc_copy_unit #(
    parameter int BUFFER_BYTES = gbc_pkg::BUFFER_BYTES_DEF,
    parameter int AW           = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gbc_pkg::t_copy_ctl i_ctl,
    input  logic [AW-1:0]      i_src,
    input  logic [AW-1:0]      i_dst,
    input  logic [AW-1:0]      i_len,
    input  logic [AW-1:0]      i_addr,
    input  logic [7:0]         i_byte,
    output logic               o_busy,
    output logic [7:0]         o_byte
);

    logic          r_run;
    logic          r_up;
    logic [AW-1:0] r_src;
    logic [AW-1:0] r_dst;
    logic [AW-1:0] r_rem;
    logic          r_wvld;
    logic [AW-1:0] r_waddr;

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    q;

    gbc_ram #(
        .DEPTH (BUFFER_BYTES),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    // read one byte a cycle, write it back the cycle after
    assign we    = r_wvld | i_ctl.wr;
    assign waddr = r_wvld ? r_waddr : i_addr;
    assign wdata = r_wvld ? q : i_byte;
    assign re    = r_run | i_ctl.rd;
    assign raddr = r_run ? r_src : i_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_wvld <= 1'b0;
        end else begin
            r_wvld <= r_run;
            if (i_ctl.start) begin
                r_run <= 1'b1;
            end else if (r_run && r_rem == AW'(1)) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= r_dst;
        if (i_ctl.start) begin
            r_up  <= i_ctl.dir_up;
            r_src <= i_src;
            r_dst <= i_dst;
            r_rem <= i_len;
        end else if (r_run) begin
            // descend when text moves up so no source byte is overwritten first
            r_src <= r_up ? r_src - 1'b1 : r_src + 1'b1;
            r_dst <= r_up ? r_dst - 1'b1 : r_dst + 1'b1;
            r_rem <= r_rem - 1'b1;
        end
    end

    assign o_busy = r_run | r_wvld;
    assign o_byte = q;

endmodule

/* sv/gap_buffer_cursor_move_core.sv */
// Sequence: writes and reads pass S_EXEC, S_READ and S_OUT, where the result strobe comes; a move
// also passes S_MSCAN for the mark scan and, unless it leaves the gap in place, S_COPY for its
// len bytes (one read-modify-write per mark, then one byte per cycle through the text).
// Throughput: one item at a time; busy stays high through S_DONE after the result beat.
// The receiver cannot stall.
// Synchronous reset: gap 1..BUFFER_BYTES-1, marks at BUFFER_BYTES-1, counts zero, text undefined.
module gap_buffer_cursor_move_core #(
    parameter int BUFFER_BYTES = gbc_pkg::BUFFER_BYTES_DEF,
    parameter int MARK_COUNT   = gbc_pkg::MARK_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  gbc_pkg::t_item                   i_item,
    output logic                             o_valid,
    output gbc_pkg::t_result                 o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gbc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW  = $clog2(BUFFER_BYTES);
    localparam int PW  = (AW > 12) ? AW : 12;
    localparam int MIW = $clog2(MARK_COUNT);
    localparam logic [PW-1:0] POS_MAX = PW'(BUFFER_BYTES - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_MSCAN = 7'b0000100,
        S_COPY  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state         r_state, n_state;
    gbc_pkg::t_item r_item;
    logic [PW-1:0]  r_gs, n_gs;
    logic [PW-1:0]  r_ge, n_ge;
    logic [14:0]    r_fore;
    logic [14:0]    r_end;

    logic                 idx_ok;
    logic                 pos_ok;
    logic [PW-1:0]        pos_w;
    logic [PW-1:0]        target;
    logic                 move_up;
    logic                 move_dn;
    logic [PW-1:0]        len_up;
    logic [PW-1:0]        len_dn;
    gbc_pkg::t_mark_ctl   mark_ctl;
    gbc_pkg::t_copy_ctl   copy_ctl;
    logic                 mark_busy;
    logic                 copy_busy;
    logic [PW-1:0]        mark_pos;
    logic [15:0]          mark_blk;
    logic [7:0]           byte_q;
    logic [AW-1:0]        copy_src;
    logic [AW-1:0]        copy_dst;
    logic [AW-1:0]        copy_len;

    assign idx_ok = int'(r_item.mark_index) < MARK_COUNT;
    assign pos_ok = int'(r_item.position) < BUFFER_BYTES;
    assign pos_w  = PW'(r_item.position);

    // clamp the move target into 1..BUFFER_BYTES-1
    assign target = (pos_w == '0) ? PW'(1) : ((pos_w > POS_MAX) ? POS_MAX : pos_w);

    assign move_up  = target < r_gs;
    assign move_dn  = target > r_ge;
    assign len_up   = r_gs - target;
    assign len_dn   = target - r_ge;
    assign copy_src = move_up ? AW'(r_gs - 1'b1) : AW'(r_ge);
    assign copy_dst = move_up ? AW'(r_ge - 1'b1) : AW'(r_gs);
    assign copy_len = move_up ? AW'(len_up) : AW'(len_dn);

    always_comb begin
        mark_ctl.scan  = r_state == S_EXEC && r_item.cmd == gbc_pkg::CMD_MOVE;
        mark_ctl.write = r_state == S_EXEC && r_item.cmd == gbc_pkg::CMD_WMARK && idx_ok;
        mark_ctl.read  = r_state == S_READ;

        copy_ctl.start  = r_state == S_MSCAN && !mark_busy && (move_up || move_dn);
        copy_ctl.dir_up = move_up;
        copy_ctl.wr     = r_state == S_EXEC && r_item.cmd == gbc_pkg::CMD_WBYTE && pos_ok;
        copy_ctl.rd     = r_state == S_READ;
    end

    gbc_mark_unit #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MARK_COUNT   (MARK_COUNT),
        .PW           (PW),
        .MIW          (MIW)
    ) u_mark (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mark_ctl),
        .i_idx       (MIW'(r_item.mark_index)),
        .i_wr_pos    (pos_w),
        .i_wr_blk    (r_item.mark_block),
        .i_target    (target),
        .i_gap_start (r_gs),
        .i_gap_end   (r_ge),
        .i_fore_cnt  (r_fore),
        .i_end_cnt   (r_end),
        .o_busy      (mark_busy),
        .o_rd_pos    (mark_pos),
        .o_rd_blk    (mark_blk)
    );

    gbc_copy_unit #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .AW           (AW)
    ) u_copy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (copy_ctl),
        .i_src   (copy_src),
        .i_dst   (copy_dst),
        .i_len   (copy_len),
        .i_addr  (AW'(r_item.position)),
        .i_byte  (r_item.text_byte),
        .o_busy  (copy_busy),
        .o_byte  (byte_q)
    );

    always_comb begin
        n_state = r_state;
        n_gs    = r_gs;
        n_ge    = r_ge;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (r_item.cmd == gbc_pkg::CMD_MOVE) ? S_MSCAN : S_READ;
            end
            S_MSCAN: begin
                if (!mark_busy) begin
                    n_state = (move_up || move_dn) ? S_COPY : S_READ;
                end
            end
            S_COPY: begin
                // gap registers stay put until the last byte lands
                if (!copy_busy) begin
                    n_state = S_READ;
                    if (move_up) begin
                        n_gs = target;
                        n_ge = r_ge - len_up;
                    end else begin
                        n_gs = r_gs + len_dn;
                        n_ge = target;
                    end
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gs    <= PW'(1);
            r_ge    <= POS_MAX;
            r_fore  <= '0;
            r_end   <= '0;
        end else begin
            r_state <= n_state;
            r_gs    <= n_gs;
            r_ge    <= n_ge;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    gbc_pkg::CFG_FORE_BLOCKS: r_fore <= i_cfg_data;
                    gbc_pkg::CFG_END_BLOCKS:  r_end  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_item <= i_item;
        end
    end

    assign busy        = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_state == S_OUT;

    always_comb begin
        o_result.gap_low        = 12'(r_gs);
        o_result.gap_high       = 12'(r_ge);
        o_result.mark_position  = idx_ok ? 12'(mark_pos) : 12'd0;
        o_result.mark_block_out = idx_ok ? mark_blk : 16'sd0;
        o_result.byte_out       = pos_ok ? byte_q : 8'd0;
    end

endmodule

/* tb/sv/gap_move_checker.sv */
`timescale 1ns / 100ps

module gap_move_checker
    import gbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_item                 i_item,
    input  logic                  i_res_valid,
    input  t_result               i_result,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int NBYTES = BUFFER_BYTES_DEF;
    localparam int NMARKS = MARK_COUNT_DEF;

    // shadow copy of the text store, gap and marks
    logic [7:0]         text_mem [NBYTES];
    int                 gap_lo;
    int                 gap_hi;
    int                 mark_pos [NMARKS];
    logic signed [15:0] mark_blk [NMARKS];
    int                 fore_cnt;
    int                 end_cnt;

    t_result due_results [$];

    // Apply one command to the shadow state and return the report it produces.
    function automatic t_result step_gap_buffer(t_item it);
        t_result r;
        int      tgt;
        int      len;
        int      p;
        int      b;
        int      k;
        bit      drop;
        case (it.cmd)
            CMD_MOVE: begin
                tgt = int'(it.position);
                if (tgt < 1)
                    tgt = 1;
                else if (tgt > NBYTES - 1)
                    tgt = NBYTES - 1;
                for (k = 0; k < NMARKS; k++) begin
                    p = mark_pos[k];
                    if (mark_blk[k] != 0) begin
                        // drop spilled marks past the configured extension
                        b = int'(mark_blk[k]);
                        if (b < 0)
                            drop = (-b - 1) > end_cnt;
                        else
                            drop = (b - 1) > fore_cnt;
                        if (drop) begin
                            mark_blk[k] = '0;
                            mark_pos[k] = 0;
                        end
                    end else if (p != 0) begin
                        if (tgt < gap_lo && p >= tgt && p <= gap_lo)
                            mark_pos[k] = gap_hi - (gap_lo - p);
                        else if (tgt > gap_hi && p >= gap_hi && p < tgt)
                            mark_pos[k] = gap_lo + (p - gap_hi);
                        else if (p >= gap_lo && p < gap_hi)
                            mark_pos[k] = gap_lo;
                    end
                end
                if (tgt < gap_lo) begin
                    len = gap_lo - tgt;
                    // destination lies above the source: copy top down
                    for (k = len - 1; k >= 0; k--)
                        text_mem[gap_hi - len + k] = text_mem[tgt + k];
                    gap_hi -= len;
                    gap_lo = tgt;
                end else if (tgt > gap_hi) begin
                    len = tgt - gap_hi;
                    for (k = 0; k < len; k++)
                        text_mem[gap_lo + k] = text_mem[gap_hi + k];
                    gap_lo += len;
                    gap_hi = tgt;
                end
            end
            CMD_WMARK: begin
                mark_pos[it.mark_index] = int'(it.position);
                mark_blk[it.mark_index] = it.mark_block;
            end
            CMD_WBYTE: begin
                text_mem[it.position] = it.text_byte;
            end
            default: ;
        endcase
        r.gap_low        = gap_lo[11:0];
        r.gap_high       = gap_hi[11:0];
        r.mark_position  = mark_pos[it.mark_index][11:0];
        r.mark_block_out = mark_blk[it.mark_index];
        r.byte_out       = text_mem[it.position];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        int      n_bad;
        n_bad = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < NBYTES; i++)
                text_mem[i] = '0;
            for (int i = 0; i < NMARKS; i++) begin
                mark_pos[i] = NBYTES - 1;
                mark_blk[i] = '0;
            end
            gap_lo   = 1;
            gap_hi   = NBYTES - 1;
            fore_cnt = 0;
            end_cnt  = 0;
            due_results.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FORE_BLOCKS: fore_cnt = int'(i_cfg_data);
                    CFG_END_BLOCKS:  end_cnt  = int'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_res_valid) begin
                if (due_results.size() == 0) begin
                    $error("result beat with no report outstanding");
                    n_bad++;
                end else begin
                    want = due_results.pop_front();
                    if (i_result.gap_low !== want.gap_low) begin
                        $error("gap_low: expected %0d, got %0d",
                               want.gap_low, i_result.gap_low);
                        n_bad++;
                    end
                    if (i_result.gap_high !== want.gap_high) begin
                        $error("gap_high: expected %0d, got %0d",
                               want.gap_high, i_result.gap_high);
                        n_bad++;
                    end
                    if (i_result.mark_position !== want.mark_position) begin
                        $error("mark_position: expected %0d, got %0d",
                               want.mark_position, i_result.mark_position);
                        n_bad++;
                    end
                    if (i_result.mark_block_out !== want.mark_block_out) begin
                        $error("mark_block_out: expected %0d, got %0d",
                               want.mark_block_out, i_result.mark_block_out);
                        n_bad++;
                    end
                    if (i_result.byte_out !== want.byte_out) begin
                        $error("byte_out: expected %0d, got %0d",
                               want.byte_out, i_result.byte_out);
                        n_bad++;
                    end
                end
            end
            if (i_start && !i_busy)
                due_results.push_back(step_gap_buffer(i_item));
            o_pending    <= due_results.size();
            o_fail_count <= o_fail_count + n_bad;
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    import gbc_pkg::*;

    localparam int NBYTES = BUFFER_BYTES_DEF;

    // indexes past the register list; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_END_BLOCKS + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_item                 i_item;
    logic                  o_valid;
    t_result               o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;

    int fore_set;
    int end_set;
    int idle_pct;
    int items_sent;
    int written_addr [$];
    bit is_written [NBYTES];

    gap_buffer_cursor_move_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    gap_move_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_res_valid  (o_valid),
        .i_result     (o_result),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Every command reads the byte at its position, so only written bytes are
    // addressed. The gap spans the whole store after reset and keeps its size,
    // so no text ever moves and written addresses stay valid.
    function automatic int pick_addr();
        return written_addr[$urandom_range(written_addr.size() - 1)];
    endfunction

    // Block numbers: in memory, just inside or outside either extension, or any.
    function automatic int choose_block();
        int                 v;
        int                 extra;
        logic signed [15:0] r16;
        extra = $urandom_range(1);
        r16   = 16'($urandom);
        case ($urandom_range(3))
            0: v = 0;
            1: begin
                v = fore_set + 1 + extra;
                if (v > 32767)
                    v = 32767;
            end
            2: begin
                v = -(end_set + 1 + extra);
                if (v < -32768)
                    v = -32768;
            end
            default: v = int'(r16);
        endcase
        return v;
    endfunction

    task automatic send_item(t_cmd c, int pos, int idx, int blk, int data_byte);
        t_item it;
        it.cmd        = c;
        it.position   = pos[11:0];
        it.mark_index = idx[3:0];
        it.mark_block = blk[15:0];
        it.text_byte  = data_byte[7:0];
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if (c == CMD_WBYTE && !is_written[it.position]) begin
            is_written[it.position] = 1'b1;
            written_addr.push_back(int'(it.position));
        end
    endtask

    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic write_regs(int fore, int tail, bit with_unused);
        cfg_beat(CFG_FORE_BLOCKS, fore);
        cfg_beat(CFG_END_BLOCKS, tail);
        if (with_unused) begin
            cfg_beat(CFG_UNUSED_LO, $urandom);
            cfg_beat(CFG_UNUSED_HI, $urandom);
        end
        i_cfg_valid <= 1'b0;
        fore_set = fore;
        end_set  = tail;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_directed();
        send_item(CMD_WBYTE, 0, 0, 0, 8'hFF);
        send_item(CMD_WBYTE, NBYTES - 1, 15, -1, 8'h00);
        send_item(CMD_WBYTE, 1, 5, 0, 8'h5A);
        send_item(CMD_WBYTE, 12'h555, 10, 0, 8'hA5);
        send_item(CMD_WBYTE, 12'hAAA, 5, 0, 8'h3C);
        send_item(CMD_WBYTE, 12'h800, 0, 0, 8'hC3);
        send_item(CMD_READ, NBYTES - 1, 15, 0, 0);
        // a target below the legal range clamps; the next one sits at its upper end
        send_item(CMD_MOVE, 0, 0, 0, 0);
        send_item(CMD_MOVE, NBYTES - 1, 1, 0, 0);
        send_item(CMD_WMARK, 0, 0, 0, 0);
        send_item(CMD_WMARK, 12'h555, 1, 0, 0);
        send_item(CMD_WMARK, 1, 2, 0, 0);
        send_item(CMD_WMARK, NBYTES - 1, 3, 0, 0);
        // spilled marks on either side of a zero-sized extension
        send_item(CMD_WMARK, 12'hAAA, 4, 32767, 0);
        send_item(CMD_WMARK, 12'h800, 5, 1, 0);
        send_item(CMD_WMARK, 12'h555, 6, 2, 0);
        send_item(CMD_WMARK, 12'hAAA, 7, -1, 0);
        send_item(CMD_WMARK, 1, 8, -2, 0);
        send_item(CMD_WMARK, 0, 15, -32768, 0);
        send_item(CMD_MOVE, 12'h800, 9, 0, 0);
        send_item(CMD_READ, 0, 1, 0, 0);
        send_item(CMD_READ, 1, 4, 0, 0);
        send_item(CMD_READ, 12'h555, 8, 0, 0);
        send_item(CMD_READ, 12'hAAA, 15, 0, 0);
    endtask

    task automatic send_random(int count);
        int stop_at;
        int sel;
        int idx;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 20) begin
                send_item(CMD_WBYTE, $urandom_range(NBYTES - 1), $urandom_range(15),
                          $urandom, $urandom);
            end else if (sel < 45) begin
                // place a mark, maybe move, then read it back
                idx = $urandom_range(15);
                send_item(CMD_WMARK, pick_addr(), idx, choose_block(), $urandom);
                if ($urandom_range(1))
                    send_item(CMD_MOVE, pick_addr(), $urandom_range(15), $urandom,
                              $urandom);
                send_item(CMD_READ, pick_addr(), idx, $urandom, $urandom);
            end else if (sel < 65) begin
                send_item(CMD_WMARK, pick_addr(), $urandom_range(15), choose_block(),
                          $urandom);
            end else if (sel < 85) begin
                send_item(CMD_MOVE, pick_addr(), $urandom_range(15), $urandom,
                          $urandom);
            end else begin
                send_item(CMD_READ, pick_addr(), $urandom_range(15), $urandom,
                          $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        idle_pct    = 0;
        items_sent  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_regs(0, 0, 1'b1);
        send_directed();
        send_random(150);
        start <= 1'b0;

        for (int phase = 1; phase < 4; phase++) begin
            wait_drained();
            case (phase)
                1: begin
                    write_regs(32767, 32767, 1'b0);
                    idle_pct = 86;
                end
                2: begin
                    write_regs($urandom_range(32767), $urandom_range(32767), 1'b1);
                    idle_pct = 30;
                end
                default: begin
                    write_regs($urandom_range(3), $urandom_range(3), 1'b0);
                    idle_pct = 0;
                end
            endcase
            send_random(150);
            start <= 1'b0;
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
